// ===== rtl/gww_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gww_pkg
// Shared widths, codes and types of the greedy word wrap streamer.
// ----------------------------------------------------------------------------
package gww_pkg;

    localparam int LEN_W  = 24;
    localparam int CODE_W = 21;
    localparam int ADV_W  = 16;
    localparam int KIND_W = 2;

    localparam int GWW_CHUNK_MAX_DEF = 32;

    localparam logic [LEN_W-1:0]  LEN_MAX    = {LEN_W{1'b1}};
    localparam logic [CODE_W-1:0] CP_NEWLINE = CODE_W'(10);
    localparam logic [CODE_W-1:0] CP_SPACE   = CODE_W'(32);

    localparam logic REQ_CHAR = 1'b0;
    localparam logic REQ_END  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_GLYPH    = 2'd0,
        KIND_LINE_END = 2'd1,
        KIND_TEXT_END = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_GLYPH,
        S_CLOSE,
        S_TEXT
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [CODE_W-1:0] glyph_code;
        logic [LEN_W-1:0]  length_out;
        logic              overflow;
        logic              last;
    } t_res;

endpackage
`default_nettype wire

// ===== rtl/gww_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gww_if
// Valid/ready channels of the streamer: character input and result output.
// ----------------------------------------------------------------------------
interface gww_in_if
    import gww_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CODE_W-1:0] codepoint;
    logic [ADV_W-1:0]  advance;

    modport source (output valid, output req_type, output codepoint, output advance,
                    input ready);
    modport sink   (input valid, input req_type, input codepoint, input advance,
                    output ready);
endinterface

interface gww_out_if
    import gww_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CODE_W-1:0] glyph_code;
    logic [LEN_W-1:0]  length_out;
    logic              overflow;
    logic              last;

    modport source (output valid, output kind, output glyph_code, output length_out,
                    output overflow, output last, input ready);
    modport sink   (input valid, input kind, input glyph_code, input length_out,
                    input overflow, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/gww_out_reg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gww_out_reg
// Single result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module gww_out_reg
    import gww_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_load,
    input  wire t_res  i_res,
    output logic       o_can_load,
    gww_out_if.source  o_out
);

    logic r_valid;
    t_res r_res;

    // slot is free when empty or when the waiting transaction completes now
    assign o_can_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.kind       = r_res.kind;
    assign o_out.glyph_code = r_res.glyph_code;
    assign o_out.length_out = r_res.length_out;
    assign o_out.overflow   = r_res.overflow;
    assign o_out.last       = r_res.last;

endmodule
`default_nettype wire

// ===== rtl/greedy_word_wrap_streamer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_word_wrap_streamer
// Greedy line breaker: buffers the current word or space run in a chunk memory
// and emits glyphs, line ends and a text end as the line fills.
// ----------------------------------------------------------------------------
//  channel   dir  handshake              payload
//  i_in      in   valid / ready          req_type, codepoint, advance
//  o_out     out  valid / ready          kind, glyph_code, length_out, overflow, last
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_wrap_width
//
//  an item is accepted in the idle state and settled in the decide state; buffered
//  glyphs then drain through the chunk memory read port after a read setup state,
//  and the line end and the text end follow
//  synchronous active-low reset; chunk memory has no clearing pass, entries
//  are only read below the fill count
//  output stalls hold the sequencer; the next item is taken while the final
//  result still sits in the output register
// ----------------------------------------------------------------------------
module greedy_word_wrap_streamer
    import gww_pkg::*;
#(
    parameter int CHUNK_MAX = GWW_CHUNK_MAX_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    gww_in_if.sink                i_in,
    gww_out_if.source             o_out,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [LEN_W-1:0] i_cfg_wrap_width
);

    localparam int AW = $clog2(CHUNK_MAX);
    localparam int CW = $clog2(CHUNK_MAX + 1);

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    // control state
    t_state           r_state, n_state;
    logic [LEN_W-1:0] r_wrap;
    logic [LEN_W-1:0] r_line_len, n_line_len;
    logic [LEN_W-1:0] r_chunk_len, n_chunk_len;
    logic [LEN_W-1:0] r_max, n_max;
    logic             r_in_sp, n_in_sp;
    logic             r_line_open, n_line_open;
    logic             r_ovf, n_ovf;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_idx, n_idx;
    logic [AW-1:0]    r_drain_last, n_drain_last;
    logic             r_close, n_close;
    logic             r_text, n_text;
    logic             r_push, n_push;

    // latched item
    logic              r_req_end;
    logic [CODE_W-1:0] r_code;
    logic [ADV_W-1:0]  r_adv;
    logic [LEN_W-1:0]  r_new_len;

    // chunk memory
    logic [CODE_W-1:0] r_mem [CHUNK_MAX];
    logic [CODE_W-1:0] r_rd_data;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    // result path
    t_res res;
    logic res_load;
    logic can_load;

    // decode
    logic             is_end, is_nl, is_sp, is_ch;
    logic [LEN_W-1:0] sum_op, sum;
    logic             past, len_nz, cnt_nz, room;
    logic             dec_place, dec_drop, dec_close, dec_push, drain;
    logic [LEN_W-1:0] adv_ext;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign adv_ext     = {{(LEN_W-ADV_W){1'b0}}, r_adv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap <= LEN_MAX;
        end else if (i_cfg_valid) begin
            r_wrap <= i_cfg_wrap_width;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req_end <= i_in.req_type;
            r_code    <= i_in.codepoint;
            r_adv     <= i_in.advance;
            r_new_len <= sat_add(r_chunk_len, {{(LEN_W-ADV_W){1'b0}}, i_in.advance});
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_code;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_comb begin
        is_end = (r_req_end == REQ_END);
        is_nl  = !is_end && (r_code == CP_NEWLINE);
        is_sp  = !is_end && (r_code == CP_SPACE);
        is_ch  = !is_end && !is_nl && !is_sp;
        // a word char outside a space run is tested with its own advance added
        sum_op = (is_ch && !r_in_sp) ? r_new_len : r_chunk_len;
        sum    = sat_add(r_line_len, sum_op);
        past   = (sum >= r_wrap);
        len_nz = (r_chunk_len != '0);
        cnt_nz = (r_count != '0);
        room   = (r_count < CW'(CHUNK_MAX));

        dec_place = (is_end && !r_in_sp && len_nz) || (is_nl && !r_in_sp && len_nz)
                 || (is_sp && !r_in_sp) || (is_ch && r_in_sp && !past);
        dec_drop  = (is_end && r_in_sp) || (is_nl && r_in_sp && len_nz)
                 || (is_ch && r_in_sp && past);
        dec_push  = is_sp || is_ch;
        dec_close = is_nl
                 || (is_end && (r_line_open || (dec_place && cnt_nz)))
                 || (is_ch && !r_in_sp && room && past && (r_line_len != '0));
        drain     = dec_place && cnt_nz;
    end

    always_comb begin
        n_state      = r_state;
        n_line_len   = r_line_len;
        n_chunk_len  = r_chunk_len;
        n_max        = r_max;
        n_in_sp      = r_in_sp;
        n_line_open  = r_line_open;
        n_ovf        = r_ovf;
        n_count      = r_count;
        n_idx        = r_idx;
        n_drain_last = r_drain_last;
        n_close      = r_close;
        n_text       = r_text;
        n_push       = r_push;
        mem_we       = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        res_load     = 1'b0;
        res          = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_close      = dec_close;
                n_text       = is_end;
                n_push       = dec_push && drain;
                n_idx        = '0;
                n_drain_last = AW'(r_count - 1'b1);
                if (dec_place) begin
                    n_line_len = sum;
                    if (cnt_nz) begin
                        n_line_open = 1'b1;
                    end
                end
                if (is_sp) begin
                    n_in_sp = 1'b1;
                end
                if (is_ch) begin
                    n_in_sp = 1'b0;
                end
                if (dec_place || dec_drop) begin
                    n_count     = '0;
                    n_chunk_len = '0;
                end
                if (drain) begin
                    n_state = S_READ;
                end else begin
                    // no glyphs to drain, so the new glyph can go in now
                    if (dec_push) begin
                        if (dec_place || dec_drop) begin
                            mem_we      = 1'b1;
                            mem_waddr   = '0;
                            n_count     = CW'(1);
                            n_chunk_len = adv_ext;
                        end else if (room) begin
                            mem_we      = 1'b1;
                            n_count     = r_count + 1'b1;
                            n_chunk_len = r_new_len;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    if (dec_close) begin
                        n_state = S_CLOSE;
                    end else if (is_end) begin
                        n_state = S_TEXT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_READ: begin
                rd_en   = 1'b1;
                rd_addr = '0;
                n_state = S_GLYPH;
            end
            S_GLYPH: begin
                if (can_load) begin
                    res_load       = 1'b1;
                    res.kind       = KIND_GLYPH;
                    res.glyph_code = r_rd_data;
                    res.overflow   = r_ovf;
                    res.last       = (r_idx == r_drain_last) && !r_close && !r_text;
                    n_ovf          = 1'b0;
                    if (r_idx != r_drain_last) begin
                        rd_en   = 1'b1;
                        rd_addr = r_idx + 1'b1;
                        n_idx   = r_idx + 1'b1;
                    end else begin
                        // chunk was emptied by the placement, new glyph goes first
                        if (r_push) begin
                            mem_we      = 1'b1;
                            mem_waddr   = '0;
                            n_count     = CW'(1);
                            n_chunk_len = adv_ext;
                            n_push      = 1'b0;
                        end
                        if (r_close) begin
                            n_state = S_CLOSE;
                        end else if (r_text) begin
                            n_state = S_TEXT;
                        end else begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            S_CLOSE: begin
                if (can_load) begin
                    res_load       = 1'b1;
                    res.kind       = KIND_LINE_END;
                    res.length_out = r_line_len;
                    res.overflow   = r_ovf;
                    res.last       = !r_text;
                    n_ovf          = 1'b0;
                    if (r_line_len > r_max) begin
                        n_max = r_line_len;
                    end
                    n_line_len  = '0;
                    n_line_open = 1'b0;
                    n_state     = r_text ? S_TEXT : S_IDLE;
                end
            end
            S_TEXT: begin
                if (can_load) begin
                    res_load       = 1'b1;
                    res.kind       = KIND_TEXT_END;
                    res.length_out = r_max;
                    res.overflow   = r_ovf;
                    res.last       = 1'b1;
                    n_line_len     = '0;
                    n_chunk_len    = '0;
                    n_max          = '0;
                    n_in_sp        = 1'b0;
                    n_line_open    = 1'b0;
                    n_ovf          = 1'b0;
                    n_count        = '0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_line_len   <= '0;
            r_chunk_len  <= '0;
            r_max        <= '0;
            r_in_sp      <= 1'b0;
            r_line_open  <= 1'b0;
            r_ovf        <= 1'b0;
            r_count      <= '0;
            r_idx        <= '0;
            r_drain_last <= '0;
            r_close      <= 1'b0;
            r_text       <= 1'b0;
            r_push       <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_line_len   <= n_line_len;
            r_chunk_len  <= n_chunk_len;
            r_max        <= n_max;
            r_in_sp      <= n_in_sp;
            r_line_open  <= n_line_open;
            r_ovf        <= n_ovf;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_drain_last <= n_drain_last;
            r_close      <= n_close;
            r_text       <= n_text;
            r_push       <= n_push;
        end
    end

    gww_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_load),
        .i_res      (res),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CHUNK_MAX))
        else $error("chunk fill count beyond depth");

    a_drain_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GLYPH) |-> (r_idx <= r_drain_last))
        else $error("drain index past last buffered glyph");

    a_text_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_load && res.kind == KIND_TEXT_END) |=>
            (r_count == '0 && r_line_len == '0 && !r_in_sp && r_state == S_IDLE))
        else $error("text state not cleared after text end");

endmodule
`default_nettype wire

// ===== bench/gww_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gww_tb_pkg
// Line layout scoreboard: predicts the glyph, line end and text end stream
// of the word wrap streamer and checks each result against it in order.
// ----------------------------------------------------------------------------
package gww_tb_pkg;

    import gww_pkg::*;

    localparam int CHUNK_DEPTH = GWW_CHUNK_MAX_DEF;
    localparam int MAX_PRINTS  = 40;

    class line_layout_sb;

        logic [LEN_W-1:0]  wrap_width;
        logic [LEN_W-1:0]  line_len;
        logic [LEN_W-1:0]  chunk_len;
        logic [LEN_W-1:0]  max_line_len;
        bit                in_space_run;
        bit                line_open;
        bit                ovf_pending;
        logic [CODE_W-1:0] chunk_codes [CHUNK_DEPTH];
        int unsigned       chunk_count;

        // expected layout results, oldest first
        t_res              layout_q[$];
        t_res              item_res[$];
        int unsigned       n_err;

        function new();
            wrap_width = LEN_MAX;
            n_err      = 0;
            clear_text();
        endfunction

        function void clear_text();
            line_len     = '0;
            chunk_len    = '0;
            max_line_len = '0;
            in_space_run = 1'b0;
            line_open    = 1'b0;
            ovf_pending  = 1'b0;
            chunk_count  = 0;
        endfunction

        function logic [LEN_W-1:0] sat_add(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
            logic [LEN_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
        endfunction

        function void emit(t_kind kind, logic [CODE_W-1:0] code, logic [LEN_W-1:0] len);
            t_res r;
            r.kind       = kind;
            r.glyph_code = code;
            r.length_out = len;
            r.overflow   = ovf_pending;
            r.last       = 1'b0;
            ovf_pending  = 1'b0;
            item_res     = {item_res, r};
        endfunction

        function void place_chunk();
            for (int i = 0; i < chunk_count; i++) begin
                emit(KIND_GLYPH, chunk_codes[i], '0);
            end
            if (chunk_count > 0) begin
                line_open = 1'b1;
            end
            line_len    = sat_add(line_len, chunk_len);
            chunk_count = 0;
            chunk_len   = '0;
        endfunction

        function void drop_chunk();
            chunk_count = 0;
            chunk_len   = '0;
        endfunction

        function void close_line();
            emit(KIND_LINE_END, '0, line_len);
            if (line_len > max_line_len) begin
                max_line_len = line_len;
            end
            line_len  = '0;
            line_open = 1'b0;
        endfunction

        // a full chunk drops the glyph and its advance
        function bit push_glyph(logic [CODE_W-1:0] code, logic [ADV_W-1:0] adv);
            if (chunk_count >= CHUNK_DEPTH) begin
                ovf_pending = 1'b1;
                return 1'b0;
            end
            chunk_codes[chunk_count] = code;
            chunk_count++;
            chunk_len = sat_add(chunk_len, LEN_W'(adv));
            return 1'b1;
        endfunction

        function bit past_width();
            return sat_add(line_len, chunk_len) >= wrap_width;
        endfunction

        function void add_item(logic rt, logic [CODE_W-1:0] code, logic [ADV_W-1:0] adv);
            item_res.delete();
            if (rt == REQ_END) begin
                if (!in_space_run) begin
                    if (chunk_len > 0) begin
                        place_chunk();
                    end
                end else begin
                    drop_chunk();
                end
                if (line_open) begin
                    close_line();
                end
                emit(KIND_TEXT_END, '0, max_line_len);
                clear_text();
            end else if (code == CP_NEWLINE) begin
                // a zero-length chunk survives the newline
                if (chunk_len > 0) begin
                    if (!in_space_run) begin
                        place_chunk();
                    end else begin
                        drop_chunk();
                    end
                end
                close_line();
            end else if (code == CP_SPACE) begin
                if (!in_space_run) begin
                    in_space_run = 1'b1;
                    place_chunk();
                end
                void'(push_glyph(CP_SPACE, adv));
            end else if (in_space_run) begin
                // the space run joins only if it stays below the width
                if (!past_width()) begin
                    place_chunk();
                end else begin
                    drop_chunk();
                end
                in_space_run = 1'b0;
                void'(push_glyph(code, adv));
            end else begin
                if (push_glyph(code, adv) && past_width() && line_len != 0) begin
                    close_line();
                end
            end
            if (item_res.size() > 0) begin
                item_res[item_res.size()-1].last = 1'b1;
            end
            layout_q = {layout_q, item_res};
        endfunction

        task report(string what);
            n_err++;
            if (n_err <= MAX_PRINTS) begin
                $display("mismatch: %s", what);
            end
        endtask

        task check_output(t_res got);
            t_res want;
            if (layout_q.size() == 0) begin
                report($sformatf("result with nothing expected: kind %0d code %0h len %0h",
                                 got.kind, got.glyph_code, got.length_out));
                return;
            end
            want = layout_q.pop_front();
            if (got.kind !== want.kind) begin
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            end
            if (got.glyph_code !== want.glyph_code) begin
                report($sformatf("glyph_code %0h, expected %0h", got.glyph_code,
                                 want.glyph_code));
            end
            if (got.length_out !== want.length_out) begin
                report($sformatf("length_out %0h, expected %0h", got.length_out,
                                 want.length_out));
            end
            if (got.overflow !== want.overflow) begin
                report($sformatf("overflow %0b, expected %0b", got.overflow, want.overflow));
            end
            if (got.last !== want.last) begin
                report($sformatf("last %0b, expected %0b", got.last, want.last));
            end
        endtask

    endclass

endpackage

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives text through the word wrap streamer under several wrap widths and
// idle patterns, and checks every glyph, line end and text end in order.
// ----------------------------------------------------------------------------
module testbench;

    import gww_pkg::*;
    import gww_tb_pkg::*;

    localparam int          LIMIT       = 500_000;
    localparam int          DRAIN_GAP   = 40;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [CODE_W-1:0] CP_MAX = CODE_W'(1114111);

    logic clk = 1'b0;
    logic rst_n;

    logic             cfg_valid;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_width;

    int unsigned idle_pct;
    int unsigned stall_pct;
    bit          pressure_on;
    bit          hold_rx;
    int unsigned n_sent;
    int unsigned cycle_cnt = 0;

    line_layout_sb sb = new();

    gww_in_if  in_ch ();
    gww_out_if out_ch ();

    greedy_word_wrap_streamer DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in             (in_ch),
        .o_out            (out_ch),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_wrap_width (cfg_width)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // transaction monitor on both channels
    always @(posedge clk) begin : watch
        t_res seen;
        if (rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.add_item(in_ch.req_type, in_ch.codepoint, in_ch.advance);
            end
            if (out_ch.valid && out_ch.ready) begin
                seen.kind       = t_kind'(out_ch.kind);
                seen.glyph_code = out_ch.glyph_code;
                seen.length_out = out_ch.length_out;
                seen.overflow   = out_ch.overflow;
                seen.last       = out_ch.last;
                sb.check_output(seen);
            end
        end
    end

    // receiver back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready = !hold_rx && ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // long receiver hold-off so the block fills and stalls its input
    initial begin
        hold_rx = 1'b0;
        wait (pressure_on);
        @(posedge clk);
        hold_rx = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx = 1'b0;
    end

    function automatic logic [ADV_W-1:0] pick_adv();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end else if (r < 9) begin
            return ADV_W'($urandom_range(0, 65535));
        end
        return ADV_W'($urandom_range(200, 900));
    endfunction

    task automatic send_item(logic rt, logic [CODE_W-1:0] code, logic [ADV_W-1:0] adv);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid = 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < idle_pct);
        end
        in_ch.valid     = 1'b1;
        in_ch.req_type  = rt;
        in_ch.codepoint = code;
        in_ch.advance   = adv;
        do @(posedge clk); while (!in_ch.ready);
        n_sent++;
    endtask

    task automatic send_word(int len, bit heavy);
        logic [CODE_W-1:0] code;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                code = CODE_W'($urandom_range(CP_SPACE + 1, CP_MAX));
            end else begin
                code = CODE_W'(8'h61 + $urandom_range(0, 25));
            end
            send_item(REQ_CHAR, code, heavy ? {ADV_W{1'b1}} : pick_adv());
        end
    endtask

    // lower valid, wait out every expected result and the tail of the pipeline
    task automatic wait_idle();
        int unsigned guard;
        guard = 0;
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (sb.layout_q.size() != 0 && guard < 100_000) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_GAP) @(posedge clk);
    endtask

    task automatic write_width(logic [LEN_W-1:0] w);
        wait_idle();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_width = w;
        do @(posedge clk); while (!cfg_ready);
        sb.wrap_width = w;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly well-formed words, space runs and newlines, some noise
    task automatic send_text(int n);
        int unsigned start;
        int unsigned r;
        int unsigned k;
        start = n_sent;
        while (n_sent - start < n) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                if ($urandom_range(0, 99) < 6) begin
                    send_word($urandom_range(30, 36), 1'b0);
                end else begin
                    send_word($urandom_range(1, 7), 1'b0);
                end
            end else if (r < 75) begin
                k = $urandom_range(1, 3);
                repeat (k) send_item(REQ_CHAR, CP_SPACE, pick_adv());
            end else if (r < 87) begin
                send_item(REQ_CHAR, CP_NEWLINE, ADV_W'($urandom_range(0, 65535)));
            end else if (r < 92) begin
                send_item(REQ_END, CODE_W'($urandom_range(0, CP_MAX)),
                          ADV_W'($urandom_range(0, 65535)));
            end else begin
                send_item(1'($urandom_range(0, 1)), CODE_W'($urandom_range(0, CP_MAX)),
                          ADV_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.req_type  = REQ_CHAR;
        in_ch.codepoint = '0;
        in_ch.advance   = '0;
        cfg_valid       = 1'b0;
        cfg_width       = '0;
        idle_pct        = 0;
        stall_pct       = 0;
        pressure_on     = 1'b0;
        n_sent          = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset width: zero advances, space run dropped at newline
        send_item(REQ_CHAR, CODE_W'(8'h41), {ADV_W{1'b1}});
        send_item(REQ_CHAR, CP_MAX, '0);
        send_item(REQ_CHAR, CP_SPACE, {ADV_W{1'b1}});
        send_item(REQ_CHAR, CP_SPACE, '0);
        send_item(REQ_CHAR, CP_NEWLINE, ADV_W'(16'h5a5a));
        send_item(REQ_CHAR, CODE_W'(8'h62), '0);
        send_item(REQ_END, CP_MAX, {ADV_W{1'b1}});

        // zero width: every word passes the width
        write_width('0);
        send_item(REQ_CHAR, CODE_W'(8'h61), ADV_W'(100));
        send_item(REQ_CHAR, CODE_W'(8'h62), ADV_W'(100));
        send_item(REQ_CHAR, CP_SPACE, ADV_W'(50));
        send_item(REQ_CHAR, CODE_W'(8'h63), '0);
        send_item(REQ_CHAR, CODE_W'(8'h64), ADV_W'(100));
        send_item(REQ_CHAR, CP_NEWLINE, '0);
        send_item(REQ_CHAR, CP_SPACE, ADV_W'(70));
        send_item(REQ_END, '0, '0);

        // line plus space run landing exactly on the width
        write_width(LEN_W'(1920));
        send_item(REQ_CHAR, CODE_W'(8'h61), ADV_W'(640));
        send_item(REQ_CHAR, CODE_W'(8'h62), ADV_W'(640));
        send_item(REQ_CHAR, CP_SPACE, ADV_W'(640));
        send_item(REQ_CHAR, CODE_W'(8'h63), ADV_W'(300));
        send_item(REQ_CHAR, CODE_W'(8'h64), ADV_W'(300));
        send_item(REQ_CHAR, CP_NEWLINE, '0);
        send_item(REQ_CHAR, CP_SPACE, ADV_W'(10));
        send_item(REQ_CHAR, CP_SPACE, ADV_W'(10));
        send_item(REQ_CHAR, CODE_W'(8'h65), {ADV_W{1'b1}});
        send_item(REQ_END, '0, '0);

        // over-long heavy words: chunk overflow and line length saturation
        write_width(LEN_MAX);
        for (int w = 0; w < 8; w++) begin
            send_word((w == 0) ? 34 : 32, 1'b1);
            send_item(REQ_CHAR, CP_SPACE, {ADV_W{1'b1}});
        end
        send_item(REQ_END, '0, '0);

        // no idling, with the receiver held off for a while
        write_width(LEN_W'(64 * 90));
        pressure_on = 1'b1;
        send_text(20);

        write_width(LEN_W'(64 * $urandom_range(40, 200)));
        idle_pct  = 84;
        stall_pct = 0;
        send_text(20);

        write_width(LEN_W'($urandom_range(0, 1500)));
        idle_pct  = 0;
        stall_pct = 84;
        send_text(20);

        write_width(LEN_W'(64 * $urandom_range(40, 200)));
        idle_pct  = 23;
        stall_pct = 23;
        send_text(20);
        send_item(REQ_END, '0, '0);

        wait_idle();
        if (sb.layout_q.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.layout_q.size()));
        end
        if (sb.n_err == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
